>>> rtl/speq_pkg.sv
// shared types, sizes and codes for the strict priority event queue
package speq_pkg;

   // sizes
   localparam int DEVICES      = 16;
   localparam int SENSOR_SLOTS = 32;
   localparam int QUEUE_DEPTH  = 16;
   localparam int LEVELS       = 3;

   localparam int MASK_W      = 16;
   localparam int KIND_W      = 2;
   localparam int DEV_W       = 4;
   localparam int SEN_W       = 8;
   localparam int PRI_W       = 2;
   localparam int TAG_W       = 8;
   localparam int STATUS_W    = 3;
   localparam int LEVEL_W     = 2;
   localparam int DEV_IDX_W   = $clog2(DEVICES);
   localparam int SLOT_W      = $clog2(SENSOR_SLOTS);
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int EVQ_ENTRIES = LEVELS * QUEUE_DEPTH;
   localparam int EVQ_ADDR_W  = $clog2(EVQ_ENTRIES);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ADD_SENSOR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REM_SENSOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ADD_EVENT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EXECUTE    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_DEVICE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SENSOR  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd5;

   // priority levels
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DEV_W-1:0]  device_id;
      logic [SEN_W-1:0]  sensor_id;
      logic [PRI_W-1:0]  priority_req;
      logic [TAG_W-1:0]  event_tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DEV_W-1:0]    out_device;
      logic [SEN_W-1:0]    out_sensor;
      logic [TAG_W-1:0]    out_tag;
      logic [LEVEL_W-1:0]  served_level;
      logic                device_now_on;
   } rsp_type;

   // work handed from the front end to the back end
   typedef enum logic [1:0] {
      OP_DONE,
      OP_ENQUEUE,
      OP_EXECUTE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [STATUS_W-1:0] status;
      logic [DEV_W-1:0]    dev;
      logic [SEN_W-1:0]    sen;
      logic [TAG_W-1:0]    tag;
      logic [LEVEL_W-1:0]  level;
   } cmd_type;

   typedef struct packed {
      logic [DEV_W-1:0] dev;
      logic [SEN_W-1:0] sen;
      logic [TAG_W-1:0] tag;
   } evq_entry_type;

endpackage

>>> rtl/speq_front.sv
// front end: device check, sensor table and command queue toward the back end
module speq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  speq_pkg::req_type             req_data,
   input  logic [speq_pkg::MASK_W-1:0]   device_mask,
   output logic                          cmd_valid,
   output speq_pkg::cmd_type             cmd_data,
   input  logic                          cmd_pop
);
   import speq_pkg::*;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // sensor table
   logic [SENSOR_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [DEV_W-1:0]        slot_owner_ff  [SENSOR_SLOTS];
   logic [SEN_W-1:0]        slot_sensor_ff [SENSOR_SLOTS];
   logic                    slot_wr;

   // command queue
   cmd_type               cmdq_mem [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;

   logic              accept;
   logic              dev_exists;
   logic              match_found, free_found;
   logic [SLOT_W-1:0] match_idx, free_idx;
   cmd_type           cmd_new;

   assign req_full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = cmdq_mem[rd_ptr_ff];

   assign dev_exists = (32'(req_data.device_id) < DEVICES) && device_mask[req_data.device_id];

   // lowest matching and lowest free slot
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      free_found  = 1'b0;
      free_idx    = '0;
      for (int i = SENSOR_SLOTS - 1; i >= 0; i--) begin
         if (slot_valid_ff[i] && slot_owner_ff[i] == req_data.device_id &&
             slot_sensor_ff[i] == req_data.sensor_id) begin
            match_found = 1'b1;
            match_idx   = SLOT_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      slot_valid_in  = slot_valid_ff;
      slot_wr        = 1'b0;
      cmd_new.op     = OP_DONE;
      cmd_new.status = STATUS_OK;
      cmd_new.dev    = req_data.device_id;
      cmd_new.sen    = req_data.sensor_id;
      cmd_new.tag    = req_data.event_tag;
      // priority code 3 folds into the low queue
      cmd_new.level  = (req_data.priority_req > PRI_W'(LEVEL_LOW)) ?
                       LEVEL_LOW : LEVEL_W'(req_data.priority_req);
      unique case (req_data.kind)
         KIND_ADD_SENSOR: begin
            if (!dev_exists) begin
               cmd_new.status = STATUS_NO_DEVICE;
            end else if (!free_found) begin
               cmd_new.status = STATUS_TABLE_FULL;
            end else if (accept) begin
               slot_valid_in[free_idx] = 1'b1;
               slot_wr                 = 1'b1;
            end
         end
         KIND_REM_SENSOR: begin
            if (!dev_exists) begin
               cmd_new.status = STATUS_NO_DEVICE;
            end else if (!match_found) begin
               cmd_new.status = STATUS_NO_SENSOR;
            end else if (accept) begin
               slot_valid_in[match_idx] = 1'b0;
            end
         end
         KIND_ADD_EVENT: begin
            if (!dev_exists) begin
               cmd_new.status = STATUS_NO_DEVICE;
            end else if (!match_found) begin
               cmd_new.status = STATUS_NO_SENSOR;
            end else begin
               cmd_new.op = OP_ENQUEUE;
            end
         end
         KIND_EXECUTE: begin
            cmd_new.op = OP_EXECUTE;
         end
         default: begin
            cmd_new.op = OP_DONE;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = accept  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMDQ_CNT_W'(accept) - CMDQ_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_owner_ff[free_idx]  <= req_data.device_id;
         slot_sensor_ff[free_idx] <= req_data.sensor_id;
      end
      if (accept) begin
         cmdq_mem[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

>>> rtl/speq_back.sv
// back end: three priority event queues, device on/off bits and result queue
module speq_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  speq_pkg::cmd_type  cmd_data,
   output logic               cmd_pop,
   output logic               rsp_empty,
   output speq_pkg::rsp_type  rsp_data,
   input  logic               rsp_pop
);
   import speq_pkg::*;

   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff, state_in;

   // queue bookkeeping
   logic [PTR_W-1:0]   heads_ff  [LEVELS];
   logic [PTR_W-1:0]   tails_ff  [LEVELS];
   logic [CNT_W-1:0]   counts_ff [LEVELS];
   logic [DEVICES-1:0] device_on_ff;

   // event storage, one region per level
   evq_entry_type       evq_mem [EVQ_ENTRIES];
   evq_entry_type       rd_entry_ff;
   logic [LEVEL_W-1:0]  rd_level_ff;

   // result queue
   rsp_type               rspq_mem [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] count_ff, count_in;

   logic                  take;
   logic                  enq_en, deq_en, tog_en, rsp_push;
   logic                  exec_any;
   logic [LEVEL_W-1:0]    exec_lvl, enq_lvl;
   logic [EVQ_ADDR_W-1:0] rd_addr, wr_addr;
   logic [DEV_IDX_W-1:0]  tog_idx;
   logic                  dev_in_range, now_on;
   evq_entry_type         wr_entry;
   rsp_type               rsp_new;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [EVQ_ADDR_W-1:0] evq_addr(input logic [LEVEL_W-1:0] lvl,
                                                      input logic [PTR_W-1:0]   ptr);
      return EVQ_ADDR_W'(lvl) * EVQ_ADDR_W'(QUEUE_DEPTH) + EVQ_ADDR_W'(ptr);
   endfunction

   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = rspq_mem[rd_ptr_ff];

   // highest non-empty level
   always_comb begin
      exec_any = 1'b1;
      priority if (counts_ff[LEVEL_HIGH] != '0) begin
         exec_lvl = LEVEL_HIGH;
      end else if (counts_ff[LEVEL_MEDIUM] != '0) begin
         exec_lvl = LEVEL_MEDIUM;
      end else if (counts_ff[LEVEL_LOW] != '0) begin
         exec_lvl = LEVEL_LOW;
      end else begin
         exec_lvl = LEVEL_HIGH;
         exec_any = 1'b0;
      end
   end

   assign enq_lvl  = cmd_data.level;
   assign rd_addr  = evq_addr(exec_lvl, heads_ff[exec_lvl]);
   assign wr_addr  = evq_addr(enq_lvl, tails_ff[enq_lvl]);
   assign wr_entry = '{dev: cmd_data.dev, sen: cmd_data.sen, tag: cmd_data.tag};

   assign tog_idx      = DEV_IDX_W'(rd_entry_ff.dev);
   assign dev_in_range = (32'(rd_entry_ff.dev) < DEVICES);
   assign now_on       = dev_in_range && !device_on_ff[tog_idx];

   assign take = (state_ff == S_IDLE) && cmd_valid && (count_ff < RSPQ_CNT_W'(RSPQ_DEPTH));

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      enq_en   = 1'b0;
      deq_en   = 1'b0;
      tog_en   = 1'b0;
      rsp_push = 1'b0;
      rsp_new  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.op)
                  OP_DONE: begin
                     rsp_push       = 1'b1;
                     rsp_new.status = cmd_data.status;
                  end
                  OP_ENQUEUE: begin
                     rsp_push = 1'b1;
                     if (counts_ff[enq_lvl] >= CNT_W'(QUEUE_DEPTH)) begin
                        rsp_new.status = STATUS_QUEUE_FULL;
                     end else begin
                        enq_en         = 1'b1;
                        rsp_new.status = STATUS_OK;
                     end
                  end
                  OP_EXECUTE: begin
                     if (exec_any) begin
                        deq_en   = 1'b1;
                        state_in = S_READ;
                     end else begin
                        rsp_push       = 1'b1;
                        rsp_new.status = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     rsp_push       = 1'b1;
                     rsp_new.status = cmd_data.status;
                  end
               endcase
            end
         end
         S_READ: begin
            // event word is back from storage
            tog_en                = dev_in_range;
            rsp_push              = 1'b1;
            rsp_new.status        = STATUS_OK;
            rsp_new.out_device    = rd_entry_ff.dev;
            rsp_new.out_sensor    = rd_entry_ff.sen;
            rsp_new.out_tag       = rd_entry_ff.tag;
            rsp_new.served_level  = rd_level_ff;
            rsp_new.device_now_on = now_on;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = rsp_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = (rsp_pop && !rsp_empty) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSPQ_CNT_W'(rsp_push) - RSPQ_CNT_W'(rsp_pop && !rsp_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heads_ff     <= '{default: '0};
         tails_ff     <= '{default: '0};
         counts_ff    <= '{default: '0};
         device_on_ff <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (enq_en) begin
            tails_ff[enq_lvl]  <= bump(tails_ff[enq_lvl]);
            counts_ff[enq_lvl] <= counts_ff[enq_lvl] + 1'b1;
         end
         if (deq_en) begin
            heads_ff[exec_lvl]  <= bump(heads_ff[exec_lvl]);
            counts_ff[exec_lvl] <= counts_ff[exec_lvl] - 1'b1;
         end
         if (tog_en) begin
            device_on_ff[tog_idx] <= now_on;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enq_en) begin
         evq_mem[wr_addr] <= wr_entry;
      end
      if (deq_en) begin
         rd_entry_ff <= evq_mem[rd_addr];
         rd_level_ff <= exec_lvl;
      end
      if (rsp_push) begin
         rspq_mem[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

>>> rtl/strict_priority_event_queue.sv
// top level of the strict priority event queue: mask register, front end, back end
// path: a pushed word passes the command queue and then the result queue; an execute that
//   finds an event also passes the registered event store read, before the device bit toggles
// throughput: one word per cycle while the command queue is not full; an execute that finds
//   an event holds the back end in S_READ while the registered event store read comes back
// reset: synchronous; clears mask, sensor valid bits, queue pointers and counts, device bits
module strict_priority_event_queue (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_push,
   output logic                         req_full,
   input  speq_pkg::req_type            req_data,
   // result side
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output speq_pkg::rsp_type            rsp_data,
   // device present mask write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [speq_pkg::MASK_W-1:0]  csr_data
);
   import speq_pkg::*;

   // device present mask; the user must write it only while the block is quiet, the block itself does not enforce it
   logic [MASK_W-1:0] mask_ff, mask_in;

   // hand-off between front and back end
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   // mask writes are always taken
   assign csr_ready = 1'b1;
   assign mask_in   = (csr_valid && csr_ready) ? csr_data : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // front end settles sensor table work and sorts what the queues must do
   speq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .device_mask (mask_ff),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   // back end runs the priority queues and builds every result word
   speq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   // back end only takes a command that the front end holds
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty hand-off queue");

   // nothing is waiting on the result side right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // event fields stay zero unless the word reports success
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != STATUS_OK) |->
      (rsp_data.out_device == '0 && rsp_data.out_sensor == '0 && rsp_data.out_tag == '0 &&
       rsp_data.served_level == '0 && rsp_data.device_now_on == 1'b0))
      else $error("event fields set on a failed result");

endmodule
